>>> rtl/core/rsd_pkg.sv
package rsd_pkg;

	localparam int DZ_W = 15;
	localparam int AXIS_W = 16;

	localparam logic [DZ_W-1:0] DZ_LEFT_RESET = 15'd7849;
	localparam logic [DZ_W-1:0] DZ_RIGHT_RESET = 15'd8689;

	// register indexes on the configuration port
	localparam logic REG_DZ_LEFT = 1'b0;
	localparam logic REG_DZ_RIGHT = 1'b1;

	localparam logic [AXIS_W-1:0] OUT_POS_MAX = 16'h7FFF;
	localparam logic [AXIS_W-1:0] OUT_NEG_MAX = 16'h8000;

	typedef struct packed {
		logic [1:0] player;
		logic stick_sel;
		logic signed [AXIS_W-1:0] raw_x;
		logic signed [AXIS_W-1:0] raw_y;
	} in_item_t;

	typedef struct packed {
		logic [1:0] player_out;
		logic signed [AXIS_W-1:0] scaled_x;
		logic signed [AXIS_W-1:0] scaled_y;
		logic in_deadzone;
	} out_item_t;

endpackage

>>> rtl/core/radial_stick_deadzone_unit.sv
// Radial dead zone and rescaling of one thumbstick sample per item. The block is a
// fixed 49-stage pipeline: one item enters every cycle while out_ready stays high, and
// its result is presented on out_data from the output register of the last stage.
// The length of the pipeline is set by the square root (one result bit per stage, 24
// stages) and the rounding divide (one quotient bit per stage, 17 stages). When a
// result waits at the output the whole pipeline holds and in_ready drops; nothing
// is lost or repeated. The user must write the dead zone registers (through
// cfg_we/cfg_idx/cfg_wdata) only while no item is in flight; no check enforces it.
module radial_stick_deadzone_unit #(
	parameter int AXIS_FULL_SCALE = 32767
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rsd_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rsd_pkg::out_item_t out_data,
	input  logic cfg_we,
	input  logic cfg_idx,
	input  logic [rsd_pkg::DZ_W-1:0] cfg_wdata
);
	import rsd_pkg::*;

	localparam logic [DZ_W-1:0] FS = DZ_W'(AXIS_FULL_SCALE);
	localparam int SQ_STEPS = 24;
	localparam int DV_STEPS = 17;
	localparam int REM_W = 27;
	localparam int DEN_W = 39;
	localparam int NUM_W = 24;
	localparam int PRD_W = 40;
	localparam int DIV_W = 58;

	typedef struct packed {
		logic [1:0] player;
		logic nx;
		logic ny;
		logic [AXIS_W-1:0] ax;
		logic [AXIS_W-1:0] ay;
		logic [DZ_W-1:0] dz;
		logic dead;
	} ctl_t;

	logic [DZ_W-1:0] dzl_q, dzr_q;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dzl_q <= DZ_LEFT_RESET;
			dzr_q <= DZ_RIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DZ_LEFT: dzl_q <= cfg_wdata;
				REG_DZ_RIGHT: dzr_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// advance everything together unless the output holds an untaken item
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: magnitudes and dead zone select
	logic v_s1;
	ctl_t c_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c_s1.player <= in_data.player;
			c_s1.nx <= in_data.raw_x[AXIS_W-1];
			c_s1.ny <= in_data.raw_y[AXIS_W-1];
			c_s1.ax <= in_data.raw_x[AXIS_W-1] ? AXIS_W'(~$unsigned(in_data.raw_x) + 16'd1)
				: $unsigned(in_data.raw_x);
			c_s1.ay <= in_data.raw_y[AXIS_W-1] ? AXIS_W'(~$unsigned(in_data.raw_y) + 16'd1)
				: $unsigned(in_data.raw_y);
			c_s1.dz <= in_data.stick_sel ? dzr_q : dzl_q;
			c_s1.dead <= 1'b0;
		end
	end

	// stage 2: squares
	logic v_s2;
	ctl_t c_s2;
	logic [31:0] sqx_s2, sqy_s2;
	logic [29:0] dz2_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c_s2 <= c_s1;
			sqx_s2 <= c_s1.ax * c_s1.ax;
			sqy_s2 <= c_s1.ay * c_s1.ay;
			dz2_s2 <= c_s1.dz * c_s1.dz;
		end
	end

	// stage 3: squared length and dead zone test; feeds the root pipeline
	logic sq_v_s [0:SQ_STEPS];
	ctl_t sq_c_s [0:SQ_STEPS];
	logic [31:0] sq_val_s [0:SQ_STEPS];
	logic [REM_W-1:0] sq_rem_s [0:SQ_STEPS];
	logic [SQ_STEPS-1:0] sq_root_s [0:SQ_STEPS];
	logic [31:0] sum_s2;
	ctl_t c_tst;

	assign sum_s2 = sqx_s2 + sqy_s2;

	always_comb begin
		c_tst = c_s2;
		c_tst.dead = sum_s2 < {2'b00, dz2_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_v_s[0] <= 1'b0;
		else if (en) sq_v_s[0] <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sq_c_s[0] <= c_tst;
			sq_val_s[0] <= sum_s2;
			sq_rem_s[0] <= '0;
			sq_root_s[0] <= '0;
		end
	end

	// root of the squared length shifted up 16 bits, one result bit per stage
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		logic [47:0] wide;
		logic [REM_W-1:0] cur, trial;
		assign wide = {sq_val_s[k], 16'h0000};
		assign cur = {sq_rem_s[k][REM_W-3:0], wide[47-2*k -: 2]};
		assign trial = REM_W'({sq_root_s[k], 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[k+1] <= 1'b0;
			else if (en) sq_v_s[k+1] <= sq_v_s[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_c_s[k+1] <= sq_c_s[k];
				sq_val_s[k+1] <= sq_val_s[k];
				if (cur >= trial) begin
					sq_rem_s[k+1] <= cur - trial;
					sq_root_s[k+1] <= {sq_root_s[k][SQ_STEPS-2:0], 1'b1};
				end else begin
					sq_rem_s[k+1] <= cur;
					sq_root_s[k+1] <= {sq_root_s[k][SQ_STEPS-2:0], 1'b0};
				end
			end
		end
	end

	// stage 28: numerator and denominator of the length remap
	logic v_s28, zero_s28;
	ctl_t c_s28;
	logic [NUM_W-1:0] num_s28;
	logic [DEN_W-1:0] den_s28;
	logic [SQ_STEPS-1:0] m8;
	logic [DZ_W-1:0] span;
	logic [NUM_W-1:0] over, cap;
	assign m8 = sq_root_s[SQ_STEPS];
	assign span = FS - sq_c_s[SQ_STEPS].dz;
	assign over = m8 - {1'b0, sq_c_s[SQ_STEPS].dz, 8'h00};
	assign cap = {1'b0, span, 8'h00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s28 <= 1'b0;
		else if (en) v_s28 <= sq_v_s[SQ_STEPS];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c_s28 <= sq_c_s[SQ_STEPS];
			zero_s28 <= m8 == '0;
			if (sq_c_s[SQ_STEPS].dz >= FS) begin
				num_s28 <= NUM_W'(256);
				den_s28 <= DEN_W'(m8);
			end else begin
				num_s28 <= (over > cap) ? cap : over;
				den_s28 <= m8 * span;
			end
		end
	end

	// stage 29: axis times numerator
	logic v_s29, zero_s29;
	ctl_t c_s29;
	logic [PRD_W-1:0] px_s29, py_s29;
	logic [DEN_W-1:0] den_s29;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s29 <= 1'b0;
		else if (en) v_s29 <= v_s28;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c_s29 <= c_s28;
			zero_s29 <= zero_s28;
			den_s29 <= den_s28;
			px_s29 <= c_s28.ax * num_s28;
			py_s29 <= c_s28.ay * num_s28;
		end
	end

	// stage 30: times full scale, doubled plus den for round half up
	logic v_s30, zero_s30;
	ctl_t c_s30;
	logic [DIV_W-1:0] nx_s30, ny_s30;
	logic [DEN_W:0] d_s30;
	logic [DIV_W-1:0] ax_full, ay_full;
	assign ax_full = ({18'd0, px_s29} << 15) - {18'd0, px_s29};
	assign ay_full = ({18'd0, py_s29} << 15) - {18'd0, py_s29};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s30 <= 1'b0;
		else if (en) v_s30 <= v_s29;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c_s30 <= c_s29;
			zero_s30 <= zero_s29;
			nx_s30 <= {ax_full[DIV_W-2:0], 1'b0} + DIV_W'(den_s29);
			ny_s30 <= {ay_full[DIV_W-2:0], 1'b0} + DIV_W'(den_s29);
			d_s30 <= {den_s29, 1'b0};
		end
	end

	// stage 31: quotient overflow check; feeds the divide pipeline
	logic dv_v_s [0:DV_STEPS];
	ctl_t dv_c_s [0:DV_STEPS];
	logic dv_zero_s [0:DV_STEPS];
	logic dv_ovx_s [0:DV_STEPS];
	logic dv_ovy_s [0:DV_STEPS];
	logic [DEN_W:0] dv_d_s [0:DV_STEPS];
	logic [DIV_W-1:0] dv_rx_s [0:DV_STEPS];
	logic [DIV_W-1:0] dv_ry_s [0:DV_STEPS];
	logic [DV_STEPS-1:0] dv_qx_s [0:DV_STEPS];
	logic [DV_STEPS-1:0] dv_qy_s [0:DV_STEPS];
	logic [DIV_W-1:0] d_top;
	assign d_top = {1'b0, d_s30, 17'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else if (en) dv_v_s[0] <= v_s30;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dv_c_s[0] <= c_s30;
			dv_zero_s[0] <= zero_s30;
			dv_ovx_s[0] <= nx_s30 >= d_top;
			dv_ovy_s[0] <= ny_s30 >= d_top;
			dv_d_s[0] <= d_s30;
			dv_rx_s[0] <= nx_s30;
			dv_ry_s[0] <= ny_s30;
			dv_qx_s[0] <= '0;
			dv_qy_s[0] <= '0;
		end
	end

	// restoring divide, one quotient bit per stage, most significant first
	for (genvar j = 0; j < DV_STEPS; j++) begin : g_div
		logic [DIV_W-1:0] dsh;
		assign dsh = {18'd0, dv_d_s[j]} << (DV_STEPS - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j+1] <= 1'b0;
			else if (en) dv_v_s[j+1] <= dv_v_s[j];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_c_s[j+1] <= dv_c_s[j];
				dv_zero_s[j+1] <= dv_zero_s[j];
				dv_ovx_s[j+1] <= dv_ovx_s[j];
				dv_ovy_s[j+1] <= dv_ovy_s[j];
				dv_d_s[j+1] <= dv_d_s[j];
				if (dv_rx_s[j] >= dsh) begin
					dv_rx_s[j+1] <= dv_rx_s[j] - dsh;
					dv_qx_s[j+1] <= {dv_qx_s[j][DV_STEPS-2:0], 1'b1};
				end else begin
					dv_rx_s[j+1] <= dv_rx_s[j];
					dv_qx_s[j+1] <= {dv_qx_s[j][DV_STEPS-2:0], 1'b0};
				end
				if (dv_ry_s[j] >= dsh) begin
					dv_ry_s[j+1] <= dv_ry_s[j] - dsh;
					dv_qy_s[j+1] <= {dv_qy_s[j][DV_STEPS-2:0], 1'b1};
				end else begin
					dv_ry_s[j+1] <= dv_ry_s[j];
					dv_qy_s[j+1] <= {dv_qy_s[j][DV_STEPS-2:0], 1'b0};
				end
			end
		end
	end

	// stage 49: sign, saturation and output register
	logic v_s49;
	out_item_t res_s49;
	logic [AXIS_W-1:0] sx, sy;
	ctl_t cf;
	logic [DV_STEPS-1:0] qx, qy;
	assign cf = dv_c_s[DV_STEPS];
	assign qx = dv_qx_s[DV_STEPS];
	assign qy = dv_qy_s[DV_STEPS];

	always_comb begin
		if (cf.nx) begin
			if (dv_ovx_s[DV_STEPS] || qx > 17'd32768) sx = OUT_NEG_MAX;
			else sx = AXIS_W'(~qx + 17'd1);
		end else begin
			if (dv_ovx_s[DV_STEPS] || qx > 17'd32767) sx = OUT_POS_MAX;
			else sx = qx[AXIS_W-1:0];
		end
		if (cf.ny) begin
			if (dv_ovy_s[DV_STEPS] || qy > 17'd32768) sy = OUT_NEG_MAX;
			else sy = AXIS_W'(~qy + 17'd1);
		end else begin
			if (dv_ovy_s[DV_STEPS] || qy > 17'd32767) sy = OUT_POS_MAX;
			else sy = qy[AXIS_W-1:0];
		end
		// drop the scaled value inside the dead zone or for a zero length
		if (cf.dead || dv_zero_s[DV_STEPS]) begin
			sx = '0;
			sy = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s49 <= 1'b0;
		else if (en) v_s49 <= dv_v_s[DV_STEPS];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			res_s49.player_out <= cf.player;
			res_s49.scaled_x <= sx;
			res_s49.scaled_y <= sy;
			res_s49.in_deadzone <= cf.dead;
		end
	end

	assign out_valid = v_s49;
	assign out_data = res_s49;

endmodule

>>> rtl/core/rsd_checker.sv
module rsd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input rsd_pkg::out_item_t out_data
);
	import rsd_pkg::*;

	// a waiting item holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output item changed while stalled");

	// the input side stalls exactly when an output item is refused
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output backpressure");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.in_deadzone |-> out_data.scaled_x == 0 && out_data.scaled_y == 0)
		else $error("dead zone item with non-zero output");

	// a refused output keeps the input side closed in the next cycle unless out_ready is then high
	a_stall_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> !in_ready || out_ready)
		else $error("input opened while output still blocked");

endmodule

bind radial_stick_deadzone_unit rsd_checker u_rsd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);
